@@ sv/neighbor_cell_sweep_defines.svh @@
// assertion macros for the neighbor cell sweep back end
`ifndef NEIGHBOR_CELL_SWEEP_DEFINES_SVH
`define NEIGHBOR_CELL_SWEEP_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off while i_rst_n is low
`define NCS_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off while i_rst_n is low
`define NCS_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ sv/nbs_pkg.sv @@
// shared types and constants of the neighbor cell sweep
`timescale 1ns / 1ps
package nbs_pkg;

    localparam int GRID_MAX  = 64;
    localparam int CRD_W     = 6;
    localparam int DIV_W     = 7;
    localparam int DXY_W     = 13;
    localparam int IDX_W     = 18;
    localparam int SPAN_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int PER_W     = 2;
    localparam int Q_DEPTH   = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIV_X    = 2'd0,
        CFG_DIV_Y    = 2'd1,
        CFG_DIV_Z    = 2'd2,
        CFG_PERIODIC = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [CRD_W-1:0] center_x;
        logic [CRD_W-1:0] center_y;
        logic [CRD_W-1:0] center_z;
        logic             halo;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0] cell_index;
        logic [CRD_W-1:0] cell_x;
        logic [CRD_W-1:0] cell_y;
        logic [CRD_W-1:0] cell_z;
        logic             last;
    } t_out_item;

    // one axis of a sweep: first grid coordinate and cells beyond it
    typedef struct packed {
        logic [CRD_W-1:0]  start;
        logic [SPAN_W-1:0] span;
    } t_axis;

    typedef struct packed {
        t_axis x;
        t_axis y;
        t_axis z;
    } t_desc;

    // grid geometry seen by the back end
    typedef struct packed {
        logic [CRD_W-1:0] top_x;
        logic [CRD_W-1:0] top_y;
        logic [CRD_W-1:0] top_z;
        logic [DIV_W-1:0] div_x;
        logic [DXY_W-1:0] div_xy;
    } t_geom;

endpackage

@@ sv/nbs_front.sv @@
// front end: configuration registers and per-request box classification
`timescale 1ns / 1ps
module nbs_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [nbs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [nbs_pkg::DIV_W-1:0]     i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  nbs_pkg::t_in_item             i_data,
    output logic                          o_push,
    output nbs_pkg::t_desc                o_desc,
    input  logic                          i_full,
    output nbs_pkg::t_geom                o_geom
);
    import nbs_pkg::*;

    logic [DIV_W-1:0] r_div_x, r_div_y, r_div_z;
    logic [PER_W-1:0] r_per;
    logic [DXY_W-1:0] r_dxy;

    logic [DIV_W-1:0]   w_eff_x, w_eff_y, w_eff_z;
    logic [DIV_W-1:0]   w_tx, w_ty, w_tz;
    logic [DXY_W:0]     w_dxy;

    function automatic logic [DIV_W-1:0] eff_div(input logic [DIV_W-1:0] d);
        logic [DIV_W-1:0] r;
        if (d == '0) begin
            r = DIV_W'(1);
        end else if (d > DIV_W'(GRID_MAX)) begin
            r = DIV_W'(GRID_MAX);
        end else begin
            r = d;
        end
        return r;
    endfunction

    function automatic t_axis axis_box(input logic [CRD_W-1:0] center, input logic h,
                                       input logic [CRD_W-1:0] top, input logic wraps);
        t_axis            a;
        logic [CRD_W-1:0] c;
        c = (center > top) ? top : center;
        if (!h) begin
            a.start = c;
            a.span  = '0;
        end else if (!wraps || (top < CRD_W'(2))) begin
            a.start = (c == '0) ? '0 : CRD_W'(c - CRD_W'(1));
            a.span  = {1'b0, (c != '0)} + {1'b0, (c != top)};
        end else begin
            a.start = (c == '0) ? top : CRD_W'(c - CRD_W'(1));
            a.span  = SPAN_W'(2);
        end
        return a;
    endfunction

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_x <= DIV_W'(1);
            r_div_y <= DIV_W'(1);
            r_div_z <= DIV_W'(1);
            r_per   <= '0;
            r_dxy   <= DXY_W'(1);
        end else begin
            r_dxy <= w_dxy[DXY_W-1:0];
            if (i_cfg_valid) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_DIV_X:    r_div_x <= i_cfg_data;
                    CFG_DIV_Y:    r_div_y <= i_cfg_data;
                    CFG_DIV_Z:    r_div_z <= i_cfg_data;
                    CFG_PERIODIC: r_per   <= i_cfg_data[PER_W-1:0];
                    default:      r_per   <= r_per;
                endcase
            end
        end
    end

    always_comb begin
        w_eff_x = eff_div(r_div_x);
        w_eff_y = eff_div(r_div_y);
        w_eff_z = eff_div(r_div_z);
        w_tx    = w_eff_x - DIV_W'(1);
        w_ty    = w_eff_y - DIV_W'(1);
        w_tz    = w_eff_z - DIV_W'(1);
        w_dxy   = (DXY_W+1)'(w_eff_x) * (DXY_W+1)'(w_eff_y);
    end

    assign o_stall  = i_full;
    assign o_push   = i_valid && !i_full;
    assign o_desc.x = axis_box(i_data.center_x, i_data.halo, w_tx[CRD_W-1:0], r_per != '0);
    assign o_desc.y = axis_box(i_data.center_y, i_data.halo, w_ty[CRD_W-1:0], r_per[1]);
    assign o_desc.z = axis_box(i_data.center_z, i_data.halo, w_tz[CRD_W-1:0], &r_per);

    assign o_geom.top_x  = w_tx[CRD_W-1:0];
    assign o_geom.top_y  = w_ty[CRD_W-1:0];
    assign o_geom.top_z  = w_tz[CRD_W-1:0];
    assign o_geom.div_x  = w_eff_x;
    assign o_geom.div_xy = r_dxy;

endmodule

@@ sv/nbs_queue.sv @@
// short descriptor queue between front and back end
`timescale 1ns / 1ps
module nbs_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  nbs_pkg::t_desc i_desc,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output nbs_pkg::t_desc o_desc
);
    import nbs_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_desc            r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_cnt;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(Q_DEPTH - 1)) ? '0 : PTR_W'(p + PTR_W'(1));
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ptr_inc(r_wp);
            end
            if (i_pop) begin
                r_rp <= ptr_inc(r_rp);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    assign o_full  = (r_cnt == CNT_W'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_desc  = r_mem[r_rp];

endmodule

@@ sv/nbs_back.sv @@
// back end: cell sequencer, index arithmetic and output register
`timescale 1ns / 1ps
`include "neighbor_cell_sweep_defines.svh"
module nbs_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  nbs_pkg::t_desc     i_desc,
    output logic               o_pop,
    input  nbs_pkg::t_geom     i_geom,
    output logic               o_valid,
    input  logic               i_stall,
    output nbs_pkg::t_out_item o_data
);
    import nbs_pkg::*;

    logic              r_busy;
    t_desc             r_desc;
    logic [CRD_W-1:0]  r_gx, r_gy, r_gz;
    logic [SPAN_W-1:0] r_rx, r_ry, r_rz;
    logic              r_out_valid;
    t_out_item         r_out;

    logic              w_emit, w_last, w_load;
    logic [DIV_W+CRD_W+DXY_W-1:0] w_idx;

    function automatic logic [CRD_W-1:0] wrap_inc(input logic [CRD_W-1:0] g,
                                                  input logic [CRD_W-1:0] top);
        return (g == top) ? '0 : CRD_W'(g + CRD_W'(1));
    endfunction

    assign w_emit = r_busy && (!r_out_valid || !i_stall);
    assign w_last = (r_rx == '0) && (r_ry == '0) && (r_rz == '0);
    assign w_load = i_q_valid && (!r_busy || (w_emit && w_last));
    assign o_pop  = w_load;

    // z*dx*dy + y*dx + x, two small products side by side
    assign w_idx = ((DIV_W+CRD_W+DXY_W)'(r_gz) * (DIV_W+CRD_W+DXY_W)'(i_geom.div_xy))
                 + ((DIV_W+CRD_W+DXY_W)'(r_gy) * (DIV_W+CRD_W+DXY_W)'(i_geom.div_x))
                 + (DIV_W+CRD_W+DXY_W)'(r_gx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_busy <= 1'b1;
            end else if (w_emit && w_last) begin
                r_busy <= 1'b0;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out.cell_index <= w_idx[IDX_W-1:0];
            r_out.cell_x     <= r_gx;
            r_out.cell_y     <= r_gy;
            r_out.cell_z     <= r_gz;
            r_out.last       <= w_last;
        end
        if (w_load) begin
            r_desc <= i_desc;
            r_gx   <= i_desc.x.start;
            r_gy   <= i_desc.y.start;
            r_gz   <= i_desc.z.start;
            r_rx   <= i_desc.x.span;
            r_ry   <= i_desc.y.span;
            r_rz   <= i_desc.z.span;
        end else if (w_emit) begin
            if (r_rx != '0) begin
                r_gx <= wrap_inc(r_gx, i_geom.top_x);
                r_rx <= r_rx - SPAN_W'(1);
            end else begin
                r_gx <= r_desc.x.start;
                r_rx <= r_desc.x.span;
                if (r_ry != '0) begin
                    r_gy <= wrap_inc(r_gy, i_geom.top_y);
                    r_ry <= r_ry - SPAN_W'(1);
                end else begin
                    r_gy <= r_desc.y.start;
                    r_ry <= r_desc.y.span;
                    r_gz <= wrap_inc(r_gz, i_geom.top_z);
                    r_rz <= r_rz - SPAN_W'(1);
                end
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    `NCS_ASSERT_NOW(a_rem_in_span, r_busy, (r_rx <= r_desc.x.span) && (r_ry <= r_desc.y.span) && (r_rz <= r_desc.z.span), "remaining count beyond span")
    `NCS_ASSERT_NOW(a_coord_in_grid, r_busy, (r_gx <= i_geom.top_x) && (r_gy <= i_geom.top_y) && (r_gz <= i_geom.top_z), "sweep coordinate outside grid")
    `NCS_ASSERT_NEXT(a_idle_after_last, w_emit && w_last && !i_q_valid, !r_busy, "sequencer busy after last cell")

endmodule

@@ sv/neighbor_cell_sweep.sv @@
// top level of the neighbor cell sweep: front end, descriptor queue, back end
`timescale 1ns / 1ps
// neighbor cell sweep: each request names a centre cell and a halo of 0 or 1
// and yields one result per cell of the surrounding box, x fastest, then y,
// then z, carrying the linear index z*div_y*div_x + y*div_x + x and the cell
// coordinates; the final result of a request has last set. a request yields
// 1 to 27 results, one per cycle while the output is not stalled, from the
// back-end cell sequencer, which loads the next request in the cycle of the
// previous last cell, so consecutive requests run back to back. the first
// result passes through the queue entry, then the sequencer load, then the
// output register, which takes the first cell. the front end classifies a
// request in the cycle it is accepted and parks it in a two-entry queue, so
// up to two requests can wait while a sweep runs and while the output is
// stalled. write configuration only when no request is in flight; div values
// of 0 act as 1, above 64 act as 64.
module neighbor_cell_sweep (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration writes, always ready
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [nbs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [nbs_pkg::DIV_W-1:0]     i_cfg_data,
    // request channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  nbs_pkg::t_in_item             i_data,
    // result channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output nbs_pkg::t_out_item            o_data
);
    import nbs_pkg::*;

    // front to queue
    logic  w_push, w_full;
    t_desc w_push_desc;
    // queue to back
    logic  w_q_valid, w_pop;
    t_desc w_q_desc;
    // grid geometry for index arithmetic
    t_geom w_geom;

    nbs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_push      (w_push),
        .o_desc      (w_push_desc),
        .i_full      (w_full),
        .o_geom      (w_geom)
    );

    nbs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_desc  (w_push_desc),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_desc  (w_q_desc)
    );

    nbs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_desc    (w_q_desc),
        .o_pop     (w_pop),
        .i_geom    (w_geom),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_data    (o_data)
    );

endmodule
